// File: rtl/bpm_pkg.sv
package bpm_pkg;

    typedef logic [2:0] opcode_t;

    localparam opcode_t OP_FETCH     = 3'd0;
    localparam opcode_t OP_UNPIN     = 3'd1;
    localparam opcode_t OP_DIRTY     = 3'd2;
    localparam opcode_t OP_FORCE_PG  = 3'd3;
    localparam opcode_t OP_FORCE_ALL = 3'd4;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_BUFFER = 2'd1;
    localparam logic [1:0] STATUS_PINNED    = 2'd2;

    localparam logic [7:0]  PIN_MAX  = 8'hFF;
    localparam logic [31:0] TICK_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic ld_req;
        logic scan_adv;
        logic resolve;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic fa_emit_need;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [3:0]  frame_out;
        logic        writeback;
        logic [7:0]  wb_file;
        logic [23:0] wb_page;
        logic        last;
    } res_t;

endpackage

// File: rtl/bpm_if.sv
interface bpm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [7:0]  file_id;
    logic [23:0] page_num;
    logic [3:0]  frame_sel;

    modport source (output valid, output opcode, output file_id, output page_num,
                    output frame_sel, input ready);
    modport sink   (input valid, input opcode, input file_id, input page_num,
                    input frame_sel, output ready);
endinterface

interface bpm_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        hit;
    logic [3:0]  frame_out;
    logic        writeback;
    logic [7:0]  wb_file;
    logic [23:0] wb_page;
    logic        last;

    modport source (output valid, output status, output hit, output frame_out,
                    output writeback, output wb_file, output wb_page, output last,
                    input ready);
    modport sink   (input valid, input status, input hit, input frame_out,
                    input writeback, input wb_file, input wb_page, input last,
                    output ready);
endinterface

// File: rtl/bpm_ctrl.sv
module bpm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  bpm_pkg::opcode_t req_opcode,
    output logic             req_ready,
    input  bpm_pkg::stat_t   st,
    output bpm_pkg::cmd_t    cmd
);
    import bpm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.ld_req = 1'b1;
                    if (req_opcode == OP_FETCH || req_opcode == OP_FORCE_PG ||
                        req_opcode == OP_FORCE_ALL)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_RESOLVE;
                    end
                end
            end
            ST_SCAN:
            begin
                // hold the scan while a force-all result cannot be parked
                cmd.scan_adv = !(st.fa_emit_need && !st.out_free);
                if (st.scan_done)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (st.out_free)
                begin
                    cmd.resolve = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/bpm_dp.sv
module bpm_dp #(
    parameter int FRAMES = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bpm_pkg::opcode_t req_opcode,
    input  logic [7:0]       req_file_id,
    input  logic [23:0]      req_page_num,
    input  logic [3:0]       req_frame_sel,
    input  bpm_pkg::cmd_t    cmd,
    output bpm_pkg::stat_t   st,
    output logic             res_valid,
    input  logic             res_ready,
    output bpm_pkg::res_t    res
);
    import bpm_pkg::*;

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);

    // tag {file, page} and stamp memories, one read and one write port
    logic [31:0] tag_mem   [FRAMES];
    logic [31:0] stamp_mem [FRAMES];
    logic [31:0] tag_q;
    logic [31:0] stamp_q;

    logic        valid_reg [FRAMES];
    logic [7:0]  pin_reg   [FRAMES];
    logic        dirty_reg [FRAMES];
    logic [31:0] tick_reg;

    opcode_t     op_reg;
    logic [7:0]  fid_reg;
    logic [23:0] pg_reg;
    logic [3:0]  sel_reg;

    logic [CW-1:0] scan_cnt_reg;
    logic          s1_vld_reg;
    logic [IW-1:0] s1_idx_reg;

    logic          hit_found_reg;
    logic [IW-1:0] hit_idx_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_idx_reg;
    logic          vic_found_reg;
    logic [IW-1:0] vic_idx_reg;
    logic [31:0]   vic_stamp_reg;
    logic [31:0]   vic_tag_reg;

    logic          pend_valid_reg;
    logic [IW-1:0] pend_idx_reg;
    logic          pend_wb_reg;
    logic [31:0]   pend_tag_reg;

    logic          out_valid_reg;
    res_t          out_reg;

    logic          issue;
    logic [IW-1:0] rd_addr;
    logic          eval;
    logic          tag_match;
    logic          fa_match;
    logic          out_free;
    logic          fa_emit;
    res_t          pend_res;

    logic          fin_emit;
    res_t          fin_res;
    logic          fin_new;
    logic          fin_touch;
    logic          fin_free;
    logic          fin_unpin;
    logic          fin_dirty;
    logic [IW-1:0] fin_idx;
    logic          sel_ok;
    logic          out_load;
    res_t          out_data;

    assign issue     = cmd.scan_adv && (scan_cnt_reg < CW'(FRAMES));
    assign rd_addr   = issue ? scan_cnt_reg[IW-1:0] : s1_idx_reg;
    assign eval      = s1_vld_reg && cmd.scan_adv;
    assign tag_match = valid_reg[s1_idx_reg] && (tag_q == {fid_reg, pg_reg});
    assign fa_match  = valid_reg[s1_idx_reg] && (tag_q[31:24] == fid_reg);
    assign out_free  = !out_valid_reg || res_ready;
    assign fa_emit   = eval && (op_reg == OP_FORCE_ALL) && fa_match && pend_valid_reg;
    assign sel_ok    = 32'(sel_reg) < 32'(FRAMES);

    assign st.scan_done    = (scan_cnt_reg == CW'(FRAMES)) && !s1_vld_reg;
    assign st.fa_emit_need = s1_vld_reg && (op_reg == OP_FORCE_ALL) && fa_match &&
                             pend_valid_reg;
    assign st.out_free     = out_free;

    always_comb
    begin
        pend_res           = '0;
        pend_res.frame_out = 4'(pend_idx_reg);
        pend_res.writeback = pend_wb_reg;
        pend_res.wb_file   = pend_wb_reg ? pend_tag_reg[31:24] : 8'd0;
        pend_res.wb_page   = pend_wb_reg ? pend_tag_reg[23:0] : 24'd0;
    end

    // final action of a request
    always_comb
    begin
        fin_emit  = 1'b1;
        fin_res   = '0;
        fin_res.last = 1'b1;
        fin_new   = 1'b0;
        fin_touch = 1'b0;
        fin_free  = 1'b0;
        fin_unpin = 1'b0;
        fin_dirty = 1'b0;
        fin_idx   = hit_idx_reg;
        case (op_reg)
            OP_FETCH:
            begin
                if (hit_found_reg)
                begin
                    fin_touch         = 1'b1;
                    fin_res.hit       = 1'b1;
                    fin_res.frame_out = 4'(hit_idx_reg);
                end
                else if (free_found_reg)
                begin
                    fin_new           = 1'b1;
                    fin_idx           = free_idx_reg;
                    fin_res.frame_out = 4'(free_idx_reg);
                end
                else if (vic_found_reg)
                begin
                    fin_new           = 1'b1;
                    fin_idx           = vic_idx_reg;
                    fin_res.frame_out = 4'(vic_idx_reg);
                    if (dirty_reg[vic_idx_reg])
                    begin
                        fin_res.writeback = 1'b1;
                        fin_res.wb_file   = vic_tag_reg[31:24];
                        fin_res.wb_page   = vic_tag_reg[23:0];
                    end
                end
                else
                begin
                    fin_res.status = STATUS_NO_BUFFER;
                end
            end
            OP_UNPIN, OP_DIRTY:
            begin
                fin_idx           = IW'(sel_reg);
                fin_unpin         = sel_ok && (op_reg == OP_UNPIN);
                fin_dirty         = sel_ok && (op_reg == OP_DIRTY);
                fin_res.frame_out = sel_reg;
            end
            OP_FORCE_PG:
            begin
                if (hit_found_reg)
                begin
                    fin_res.frame_out = 4'(hit_idx_reg);
                    if (pin_reg[hit_idx_reg] != 8'd0)
                    begin
                        fin_res.status = STATUS_PINNED;
                    end
                    else
                    begin
                        fin_free = 1'b1;
                        if (dirty_reg[hit_idx_reg])
                        begin
                            fin_res.writeback = 1'b1;
                            fin_res.wb_file   = fid_reg;
                            fin_res.wb_page   = pg_reg;
                        end
                    end
                end
            end
            OP_FORCE_ALL:
            begin
                fin_emit     = pend_valid_reg;
                fin_res      = pend_res;
                fin_res.last = 1'b1;
            end
            default:
            begin
                fin_res      = '0;
                fin_res.last = 1'b1;
            end
        endcase
    end

    assign out_load = fa_emit || (cmd.resolve && fin_emit);
    assign out_data = fa_emit ? pend_res : fin_res;

    always_ff @(posedge clk)
    begin
        tag_q   <= tag_mem[rd_addr];
        stamp_q <= stamp_mem[rd_addr];
        if (cmd.resolve && (fin_new || fin_touch))
        begin
            stamp_mem[fin_idx] <= tick_reg;
        end
        if (cmd.resolve && fin_new)
        begin
            tag_mem[fin_idx] <= {fid_reg, pg_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                valid_reg[i] <= 1'b0;
                pin_reg[i]   <= 8'd0;
                dirty_reg[i] <= 1'b0;
            end
            tick_reg       <= '0;
            scan_cnt_reg   <= '0;
            s1_vld_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.ld_req)
            begin
                scan_cnt_reg   <= '0;
                s1_vld_reg     <= 1'b0;
                pend_valid_reg <= 1'b0;
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
                vic_found_reg  <= 1'b0;
            end
            else if (cmd.scan_adv)
            begin
                s1_vld_reg <= issue;
                if (issue)
                begin
                    s1_idx_reg   <= scan_cnt_reg[IW-1:0];
                    scan_cnt_reg <= scan_cnt_reg + CW'(1);
                end
            end

            if (eval)
            begin
                if (tag_match && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                    hit_idx_reg   <= s1_idx_reg;
                end
                if (!valid_reg[s1_idx_reg] && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= s1_idx_reg;
                end
                if (pin_reg[s1_idx_reg] == 8'd0 &&
                    (!vic_found_reg || stamp_q < vic_stamp_reg))
                begin
                    vic_found_reg <= 1'b1;
                    vic_idx_reg   <= s1_idx_reg;
                    vic_stamp_reg <= stamp_q;
                    vic_tag_reg   <= tag_q;
                end
                if (op_reg == OP_FORCE_ALL && fa_match)
                begin
                    pend_valid_reg         <= 1'b1;
                    pend_idx_reg           <= s1_idx_reg;
                    pend_wb_reg            <= dirty_reg[s1_idx_reg];
                    pend_tag_reg           <= tag_q;
                    valid_reg[s1_idx_reg]  <= 1'b0;
                    dirty_reg[s1_idx_reg]  <= 1'b0;
                end
            end

            if (cmd.resolve)
            begin
                if (fin_touch && pin_reg[fin_idx] != PIN_MAX)
                begin
                    pin_reg[fin_idx] <= pin_reg[fin_idx] + 8'd1;
                end
                if (fin_new)
                begin
                    valid_reg[fin_idx] <= 1'b1;
                    pin_reg[fin_idx]   <= 8'd1;
                    dirty_reg[fin_idx] <= 1'b0;
                end
                if ((fin_new || fin_touch) && tick_reg != TICK_MAX)
                begin
                    tick_reg <= tick_reg + 32'd1;
                end
                if (fin_free)
                begin
                    valid_reg[fin_idx] <= 1'b0;
                    dirty_reg[fin_idx] <= 1'b0;
                end
                if (fin_unpin && pin_reg[fin_idx] != 8'd0)
                begin
                    pin_reg[fin_idx] <= pin_reg[fin_idx] - 8'd1;
                end
                if (fin_dirty)
                begin
                    dirty_reg[fin_idx] <= 1'b1;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_req)
        begin
            op_reg  <= req_opcode;
            fid_reg <= req_file_id;
            pg_reg  <= req_page_num;
            sel_reg <= req_frame_sel;
        end
        if (out_load)
        begin
            out_reg <= out_data;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

// File: rtl/buffer_pool_lru_pin_manager.sv
// LRU buffer pool manager for FRAMES page frames with pin counts. Requests
// arrive on req (fetch, unpin, mark dirty, force page, force all of a file)
// and results leave on res through an output register. Fetch and both force
// operations scan the frame table one frame per cycle through the single
// read port of the tag/stamp memory, the scan held while a force-all result
// cannot be parked in the output register; unpin and mark dirty skip the
// scan. One request is worked at a time. Force all gives one result per
// resident frame of the file, last set on the final one, and none at all if
// the file holds no frame. Frame tags and stamps come out of reset undefined;
// only the valid, pin and dirty marks and the fetch tick are cleared, so the
// pool is ready right after reset.
module buffer_pool_lru_pin_manager #(
    parameter int FRAMES = 16
) (
    input logic   clk,
    input logic   rst_n,
    bpm_req_if.sink   req,
    bpm_res_if.source res
);
    import bpm_pkg::*;

    cmd_t  cmd;
    stat_t st;
    res_t  res_data;

    // sequencer: accept, scan, resolve
    bpm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_opcode (req.opcode),
        .req_ready  (req.ready),
        .st         (st),
        .cmd        (cmd)
    );

    // frame table, scan trackers and result register
    bpm_dp #(
        .FRAMES (FRAMES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_opcode    (req.opcode),
        .req_file_id   (req.file_id),
        .req_page_num  (req.page_num),
        .req_frame_sel (req.frame_sel),
        .cmd           (cmd),
        .st            (st),
        .res_valid     (res.valid),
        .res_ready     (res.ready),
        .res           (res_data)
    );

    assign res.status    = res_data.status;
    assign res.hit       = res_data.hit;
    assign res.frame_out = res_data.frame_out;
    assign res.writeback = res_data.writeback;
    assign res.wb_file   = res_data.wb_file;
    assign res.wb_page   = res_data.wb_page;
    assign res.last      = res_data.last;

endmodule

// File: rtl/bpm_checker.sv
module bpm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  res_status,
    input logic        res_hit,
    input logic        res_writeback,
    input logic [7:0]  res_wb_file,
    input logic [23:0] res_wb_page,
    input logic        res_last
);
    import bpm_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_hit |-> res_status == STATUS_OK && !res_writeback && res_last)
        else $error("hit with bad status or writeback");

    a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_writeback |-> res_wb_file == 8'd0 && res_wb_page == 24'd0)
        else $error("writeback tag without writeback");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != STATUS_OK |-> res_last && !res_writeback)
        else $error("error result not final or with writeback");

endmodule

bind buffer_pool_lru_pin_manager bpm_checker u_bpm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_status    (res.status),
    .res_hit       (res.hit),
    .res_writeback (res.writeback),
    .res_wb_file   (res.wb_file),
    .res_wb_page   (res.wb_page),
    .res_last      (res.last)
);

// File: tb/sv/buffer_pool_lru_pin_manager_tb.sv
`timescale 1ns / 100ps

module buffer_pool_lru_pin_manager_tb;
    import bpm_pkg::*;

    localparam int FRAMES = 16;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_REQUESTS = 300;
    localparam int HOLD_CYCLES = 400;
    // Pin count saturates at PIN_MAX, so a few more hits than that.
    localparam int PIN_STORM = 260;
    // Any code above the last defined operation is an unknown request.
    localparam opcode_t OP_UNKNOWN_LO = OP_FORCE_ALL + 3'd1;
    localparam opcode_t OP_UNKNOWN_HI = 3'd7;

    logic clk;
    logic rst_n;

    bpm_req_if req_ch ();
    bpm_res_if res_ch ();

    buffer_pool_lru_pin_manager #(
        .FRAMES(FRAMES)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .res  (res_ch)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Pool mirror: our own copy of the frame table and the fetch tick.
    // ------------------------------------------------------------------
    logic        pool_valid [FRAMES];
    logic [7:0]  pool_file  [FRAMES];
    logic [23:0] pool_page  [FRAMES];
    logic [7:0]  pool_pins  [FRAMES];
    logic        pool_dirty [FRAMES];
    logic [31:0] pool_stamp [FRAMES];
    logic [31:0] pool_tick;

    // Results owed by the block, oldest first.
    res_t owed_results[$];

    int  error_count;
    int  cycle_count;
    bit  no_idle;      // both sides run flat out while set
    bit  hold_ask;     // sender asks the receiver for a long hold-off
    int  hold_left;
    int  seg_left;
    bit  seg_ready;

    function automatic res_t make_res(logic [1:0] status, logic hit, logic [3:0] frame,
                                      logic wb, logic [7:0] wf, logic [23:0] wp,
                                      logic last);
        res_t r;
        r.status    = status;
        r.hit       = hit;
        r.frame_out = frame;
        r.writeback = wb;
        r.wb_file   = wb ? wf : 8'd0;
        r.wb_page   = wb ? wp : 24'd0;
        r.last      = last;
        return r;
    endfunction

    // Work out the results of one request and advance the mirror.
    task automatic predict_pool(input opcode_t op, input logic [7:0] fid,
                                input logic [23:0] pg, input logic [3:0] sel,
                                ref res_t outq[$]);
        int   v;
        int   n;
        logic wb;
        logic [7:0]  wf;
        logic [23:0] wp;
        v  = -1;
        n  = 0;
        wb = 1'b0;
        wf = '0;
        wp = '0;
        case (op)
            OP_FETCH:
            begin
                for (int i = 0; i < FRAMES; i++)
                    if (v < 0 && pool_valid[i] && pool_file[i] == fid && pool_page[i] == pg)
                        v = i;
                if (v >= 0)
                begin
                    // hit: pin (saturating) and restamp
                    if (pool_pins[v] != PIN_MAX)
                        pool_pins[v]++;
                    pool_stamp[v] = pool_tick;
                    if (pool_tick != TICK_MAX)
                        pool_tick++;
                    outq.push_back(make_res(STATUS_OK, 1'b1, v[3:0], 1'b0, '0, '0, 1'b1));
                end
                else
                begin
                    for (int i = 0; i < FRAMES; i++)
                        if (v < 0 && !pool_valid[i])
                            v = i;
                    if (v < 0)
                    begin
                        // least recently stamped unpinned frame, lowest index on ties
                        for (int i = 0; i < FRAMES; i++)
                            if (pool_pins[i] == 0 && (v < 0 || pool_stamp[i] < pool_stamp[v]))
                                v = i;
                        if (v >= 0 && pool_dirty[v])
                        begin
                            wb = 1'b1;
                            wf = pool_file[v];
                            wp = pool_page[v];
                        end
                    end
                    if (v < 0)
                        outq.push_back(make_res(STATUS_NO_BUFFER, 1'b0, '0, 1'b0, '0, '0,
                                                1'b1));
                    else
                    begin
                        pool_valid[v] = 1'b1;
                        pool_file[v]  = fid;
                        pool_page[v]  = pg;
                        pool_pins[v]  = 8'd1;
                        pool_dirty[v] = 1'b0;
                        pool_stamp[v] = pool_tick;
                        if (pool_tick != TICK_MAX)
                            pool_tick++;
                        outq.push_back(make_res(STATUS_OK, 1'b0, v[3:0], wb, wf, wp, 1'b1));
                    end
                end
            end
            OP_UNPIN, OP_DIRTY:
            begin
                if (int'(sel) < FRAMES)
                begin
                    if (op == OP_UNPIN)
                    begin
                        if (pool_pins[sel] != 0)
                            pool_pins[sel]--;
                    end
                    else
                        pool_dirty[sel] = 1'b1;
                end
                outq.push_back(make_res(STATUS_OK, 1'b0, sel, 1'b0, '0, '0, 1'b1));
            end
            OP_FORCE_PG:
            begin
                for (int i = 0; i < FRAMES; i++)
                    if (v < 0 && pool_valid[i] && pool_file[i] == fid && pool_page[i] == pg)
                        v = i;
                if (v < 0)
                    outq.push_back(make_res(STATUS_OK, 1'b0, '0, 1'b0, '0, '0, 1'b1));
                else if (pool_pins[v] != 0)
                    outq.push_back(make_res(STATUS_PINNED, 1'b0, v[3:0], 1'b0, '0, '0, 1'b1));
                else
                begin
                    outq.push_back(make_res(STATUS_OK, 1'b0, v[3:0], pool_dirty[v],
                                            pool_file[v], pool_page[v], 1'b1));
                    pool_dirty[v] = 1'b0;
                    pool_valid[v] = 1'b0;
                end
            end
            OP_FORCE_ALL:
            begin
                // pins are ignored and kept; no frame of the file means no result
                for (int i = 0; i < FRAMES; i++)
                begin
                    if (pool_valid[i] && pool_file[i] == fid)
                    begin
                        outq.push_back(make_res(STATUS_OK, 1'b0, i[3:0], pool_dirty[i],
                                                pool_file[i], pool_page[i], 1'b0));
                        pool_dirty[i] = 1'b0;
                        pool_valid[i] = 1'b0;
                        n++;
                    end
                end
                if (n > 0)
                    outq[outq.size() - 1].last = 1'b1;
            end
            default:
                outq.push_back(make_res(STATUS_OK, 1'b0, '0, 1'b0, '0, '0, 1'b1));
        endcase
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        error_count++;
        $display("cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    endtask

    // Mostly back to back, sometimes short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 45);
    endfunction

    // Queue the results of one request, then offer it until it is taken.
    // Typed rows carry their own single expected result.
    task automatic issue(input opcode_t op, input logic [7:0] fid, input logic [23:0] pg,
                         input logic [3:0] sel, input bit typed, input res_t want);
        res_t pred[$];
        int   gap;
        predict_pool(op, fid, pg, sel, pred);
        if (typed)
            owed_results.push_back(want);
        else
            foreach (pred[i])
                owed_results.push_back(pred[i]);
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= op;
        req_ch.file_id   <= fid;
        req_ch.page_num  <= pg;
        req_ch.frame_sel <= sel;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic issue_plain(input opcode_t op, input logic [7:0] fid,
                               input logic [23:0] pg, input logic [3:0] sel);
        issue(op, fid, pg, sel, 1'b0, '0);
    endtask

    // Sender stops until every owed result is in.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (owed_results.size() > 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        opcode_t     op;
        logic [7:0]  fid;
        logic [23:0] pg;
        logic [3:0]  sel;
        bit          typed;
        res_t        want;
    } row_t;

    row_t dir_rows[$];

    function automatic row_t mk_row(opcode_t op, logic [7:0] fid, logic [23:0] pg,
                                    logic [3:0] sel, bit typed, res_t want);
        row_t r;
        r.op    = op;
        r.fid   = fid;
        r.pg    = pg;
        r.sel   = sel;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random ready, with a long hold-off on request.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_ask)
        begin
            hold_ask  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (no_idle)
            res_ch.ready <= 1'b1;
        else
        begin
            if (seg_left == 0)
            begin
                seg_ready = ($urandom_range(0, 99) < 70);
                if (seg_ready)
                    seg_left = $urandom_range(1, 20);
                else if ($urandom_range(0, 9) == 0)
                    seg_left = $urandom_range(15, 60);
                else
                    seg_left = $urandom_range(1, 3);
            end
            res_ch.ready <= seg_ready;
            seg_left--;
        end
    end

    // Result checker: every accepted result against the oldest owed one.
    always @(posedge clk)
    begin
        res_t w;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (owed_results.size() == 0)
                report("result with none owed, frame", res_ch.frame_out, '0);
            else
            begin
                w = owed_results.pop_front();
                if (res_ch.status !== w.status)
                    report("status", res_ch.status, w.status);
                if (res_ch.hit !== w.hit)
                    report("hit", res_ch.hit, w.hit);
                if (res_ch.frame_out !== w.frame_out)
                    report("frame_out", res_ch.frame_out, w.frame_out);
                if (res_ch.writeback !== w.writeback)
                    report("writeback", res_ch.writeback, w.writeback);
                if (res_ch.wb_file !== w.wb_file)
                    report("wb_file", res_ch.wb_file, w.wb_file);
                if (res_ch.wb_page !== w.wb_page)
                    report("wb_page", res_ch.wb_page, w.wb_page);
                if (res_ch.last !== w.last)
                    report("last", res_ch.last, w.last);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int          sent;
        int          ep;
        int          r;
        bit          held;
        bit          stormed;
        opcode_t     op;
        logic [7:0]  fid;
        logic [23:0] pg;

        error_count = 0;
        cycle_count = 0;
        no_idle     = 1'b0;
        hold_ask    = 1'b0;
        hold_left   = 0;
        seg_left    = 0;
        seg_ready   = 1'b0;
        sent        = 0;
        held        = 1'b0;
        stormed     = 1'b0;
        for (int i = 0; i < FRAMES; i++)
        begin
            pool_valid[i] = 1'b0;
            pool_file[i]  = '0;
            pool_page[i]  = '0;
            pool_pins[i]  = '0;
            pool_dirty[i] = 1'b0;
            pool_stamp[i] = '0;
        end
        pool_tick = '0;

        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.opcode    <= OP_FETCH;
        req_ch.file_id   <= '0;
        req_ch.page_num  <= '0;
        req_ch.frame_sel <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty pool, extremes of tag fields, the pinned/dirty force paths,
        // unpin saturating at zero, dirty mark on a free frame, force all
        // over pinned frames and over a file with no frame.
        dir_rows.push_back(mk_row(OP_UNKNOWN_HI, 8'hFF, 24'hFFFFFF, 4'hF, 1'b1,
            make_res(STATUS_OK, 1'b0, 4'd0, 1'b0, '0, '0, 1'b1)));
        dir_rows.push_back(mk_row(OP_FORCE_PG, 8'h12, 24'h345678, 4'h0, 1'b1,
            make_res(STATUS_OK, 1'b0, 4'd0, 1'b0, '0, '0, 1'b1)));
        dir_rows.push_back(mk_row(OP_FORCE_ALL, 8'h12, 24'h0, 4'h0, 1'b0, '0));
        dir_rows.push_back(mk_row(OP_UNPIN, 8'h00, 24'h0, 4'hF, 1'b1,
            make_res(STATUS_OK, 1'b0, 4'd15, 1'b0, '0, '0, 1'b1)));
        dir_rows.push_back(mk_row(OP_DIRTY, 8'h00, 24'h0, 4'h0, 1'b1,
            make_res(STATUS_OK, 1'b0, 4'd0, 1'b0, '0, '0, 1'b1)));
        // miss into the first free frame clears its stray dirty mark
        dir_rows.push_back(mk_row(OP_FETCH, 8'hFF, 24'hFFFFFF, 4'h0, 1'b1,
            make_res(STATUS_OK, 1'b0, 4'd0, 1'b0, '0, '0, 1'b1)));
        dir_rows.push_back(mk_row(OP_FETCH, 8'hFF, 24'hFFFFFF, 4'h0, 1'b1,
            make_res(STATUS_OK, 1'b1, 4'd0, 1'b0, '0, '0, 1'b1)));
        dir_rows.push_back(mk_row(OP_DIRTY, 8'h00, 24'h0, 4'h0, 1'b1,
            make_res(STATUS_OK, 1'b0, 4'd0, 1'b0, '0, '0, 1'b1)));
        dir_rows.push_back(mk_row(OP_FORCE_PG, 8'hFF, 24'hFFFFFF, 4'h0, 1'b1,
            make_res(STATUS_PINNED, 1'b0, 4'd0, 1'b0, '0, '0, 1'b1)));
        for (int i = 0; i < 3; i++)
            dir_rows.push_back(mk_row(OP_UNPIN, 8'h00, 24'h0, 4'h0, 1'b1,
                make_res(STATUS_OK, 1'b0, 4'd0, 1'b0, '0, '0, 1'b1)));
        dir_rows.push_back(mk_row(OP_FORCE_PG, 8'hFF, 24'hFFFFFF, 4'h0, 1'b1,
            make_res(STATUS_OK, 1'b0, 4'd0, 1'b1, 8'hFF, 24'hFFFFFF, 1'b1)));
        dir_rows.push_back(mk_row(OP_FETCH, 8'h00, 24'h000000, 4'h0, 1'b1,
            make_res(STATUS_OK, 1'b0, 4'd0, 1'b0, '0, '0, 1'b1)));
        dir_rows.push_back(mk_row(OP_FETCH, 8'h01, 24'h000001, 4'h0, 1'b1,
            make_res(STATUS_OK, 1'b0, 4'd1, 1'b0, '0, '0, 1'b1)));
        dir_rows.push_back(mk_row(OP_FETCH, 8'h01, 24'h800000, 4'h0, 1'b0, '0));
        dir_rows.push_back(mk_row(OP_DIRTY, 8'h00, 24'h0, 4'h1, 1'b0, '0));
        dir_rows.push_back(mk_row(OP_UNPIN, 8'h00, 24'h0, 4'h1, 1'b0, '0));
        dir_rows.push_back(mk_row(OP_FORCE_ALL, 8'h01, 24'h0, 4'h0, 1'b0, '0));
        dir_rows.push_back(mk_row(OP_FETCH, 8'h00, 24'h000000, 4'h0, 1'b0, '0));
        dir_rows.push_back(mk_row(OP_FORCE_ALL, 8'h00, 24'h0, 4'h0, 1'b0, '0));
        dir_rows.push_back(mk_row(OP_DIRTY, 8'h00, 24'h0, 4'hF, 1'b0, '0));
        dir_rows.push_back(mk_row(OP_FETCH, 8'hAA, 24'h555555, 4'h0, 1'b0, '0));
        dir_rows.push_back(mk_row(OP_FORCE_ALL, 8'hAA, 24'h0, 4'h0, 1'b0, '0));
        dir_rows.push_back(mk_row(OP_UNKNOWN_LO, 8'h55, 24'hAAAAAA, 4'hA, 1'b0, '0));

        foreach (dir_rows[i])
            issue(dir_rows[i].op, dir_rows[i].fid, dir_rows[i].pg, dir_rows[i].sel,
                  dir_rows[i].typed, dir_rows[i].want);

        // Random part, in episodes. Small file/page pools give hits and
        // victims; full-range values now and then cover every tag bit.
        while (sent < RANDOM_REQUESTS)
        begin
            ep = $urandom_range(0, 9);
            no_idle = ($urandom_range(0, 5) == 0);

            // Once: drain, then hammer one page until its pin count pegs,
            // then free it with force all.
            if (!stormed && sent >= 20)
            begin
                stormed = 1'b1;
                drain();
                no_idle = 1'b1;
                for (int i = 0; i < PIN_STORM; i++)
                    issue_plain(OP_FETCH, 8'hC3, 24'h00C0DE, 4'h0);
                no_idle = 1'b0;
                issue_plain(OP_FORCE_ALL, 8'hC3, 24'h0, 4'h0);
                sent += PIN_STORM + 1;
            end

            // Once: receiver holds off while requests keep coming.
            if (!held && sent > 200)
            begin
                held = 1'b1;
                hold_ask = 1'b1;
                no_idle = 1'b1;
            end

            if (ep == 0)
            begin
                // fill the pool with pinned pages until no frame is free,
                // then release most of them
                for (int i = 0; i < FRAMES + 2; i++)
                begin
                    issue_plain(OP_FETCH, 8'($urandom_range(0, 255)), 24'($urandom()),
                                4'h0);
                    sent++;
                end
                for (int i = 0; i < FRAMES + 4; i++)
                begin
                    issue_plain(OP_UNPIN, '0, '0, 4'($urandom_range(0, FRAMES - 1)));
                    sent++;
                end
            end
            else
            begin
                for (int i = 0; i < 20; i++)
                begin
                    r = $urandom_range(0, 99);
                    if ($urandom_range(0, 7) == 0)
                    begin
                        fid = 8'($urandom_range(0, 255));
                        pg  = 24'($urandom());
                    end
                    else
                    begin
                        fid = 8'($urandom_range(0, 3));
                        pg  = 24'($urandom_range(0, 7));
                    end
                    if (r < 40)
                        op = OP_FETCH;
                    else if (r < 68)
                        op = OP_UNPIN;
                    else if (r < 82)
                        op = OP_DIRTY;
                    else if (r < 92)
                        op = OP_FORCE_PG;
                    else if (r < 97)
                        op = OP_FORCE_ALL;
                    else
                        op = opcode_t'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
                    issue_plain(op, fid, pg, 4'($urandom_range(0, 15)));
                    sent++;
                end
            end
            no_idle = 1'b0;
        end

        req_ch.valid <= 1'b0;
        while (owed_results.size() > 0)
            @(posedge clk);
        // tail: room for any stray result after the last owed one
        repeat (FRAMES * 4) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
